// ===== rtl/core/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and constants of the brace depth lexer.
// ----------------------------------------------------------------------------
package cbd_pkg;

   localparam int DEPTH_BITS_DEF = 16;
   localparam int OUT_DEPTH_W    = 16;
   localparam int CH_W           = 8;
   localparam int REQ_TDATA_W    = 8;
   localparam int RSP_TDATA_W    = 24;

   localparam logic [CH_W-1:0] CH_LBRACE    = 8'h7B;
   localparam logic [CH_W-1:0] CH_RBRACE    = 8'h7D;
   localparam logic [CH_W-1:0] CH_STAR      = 8'h2A;
   localparam logic [CH_W-1:0] CH_SLASH     = 8'h2F;
   localparam logic [CH_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [CH_W-1:0] CH_SQUOTE    = 8'h27;
   localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5C;

   localparam logic CMD_CHAR  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic blk;
      logic str;
      logic chr;
      logic skip;
   } cbd_flags_type;

endpackage

// ===== rtl/core/cbd_decide.sv =====
// ----------------------------------------------------------------------------
// cbd_decide
// Decides one source character against its lookahead: comment and literal
// tracking, line-comment skip, escapes and saturating brace counting.
// ----------------------------------------------------------------------------
module cbd_decide
   import cbd_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  cbd_flags_type         flags_i,
   input  logic [DEPTH_BITS-1:0] depth_i,
   input  logic [CH_W-1:0]       c_i,
   input  logic [CH_W-1:0]       la_i,
   input  logic                  la_ok_i,
   output cbd_flags_type         flags_o,
   output logic [DEPTH_BITS-1:0] depth_o,
   output logic                  consumed_o
);

   localparam logic [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

   logic          plain;
   logic          la_slash;
   cbd_flags_type lit;

   assign plain    = !flags_i.str && !flags_i.chr;
   assign la_slash = la_ok_i && (la_i == CH_SLASH);

   always_comb begin
      lit = flags_i;
      if (!flags_i.chr && c_i == CH_DQUOTE) begin
         lit.str = !flags_i.str;
      end else if (!flags_i.str && c_i == CH_SQUOTE) begin
         lit.chr = !flags_i.chr;
      end
   end

   always_comb begin
      flags_o    = flags_i;
      depth_o    = depth_i;
      consumed_o = 1'b0;
      if (flags_i.skip) begin
         consumed_o = 1'b0;
      end else if (flags_i.blk) begin
         if (c_i == CH_STAR && la_slash) begin
            flags_o.blk = 1'b0;
            consumed_o  = 1'b1;
         end
      end else if (plain && c_i == CH_SLASH && la_ok_i && la_i == CH_STAR) begin
         flags_o.blk = 1'b1;
         consumed_o  = 1'b1;
      end else if (plain && c_i == CH_SLASH && la_slash) begin
         flags_o.skip = 1'b1;
         consumed_o   = 1'b1;
      end else if (c_i == CH_BACKSLASH && la_ok_i) begin
         consumed_o = 1'b1;
      end else begin
         flags_o = lit;
         if (!lit.str && !lit.chr) begin
            if (c_i == CH_LBRACE && depth_i != DMAX) begin
               depth_o = depth_i + DEPTH_BITS'(1);
            end else if (c_i == CH_RBRACE && depth_i != DMIN) begin
               depth_o = depth_i - DEPTH_BITS'(1);
            end
         end
      end
   end

endmodule

// ===== rtl/core/c_brace_depth_lexer_top.sv =====
// ----------------------------------------------------------------------------
// c_brace_depth_lexer_top
// Brace nesting depth tracker for a C source character stream, aware of
// block and line comments, string and character literals and escapes.
// ----------------------------------------------------------------------------
//   channel | direction | tdata                  | tuser | tlast
//   req     | in        | ch                     | cmd   | end_of_line
//   rsp     | out       | depth, flags (3 bits)  | -     | -
//
// One beat per cycle sustained while rsp is taken; an accepted beat loads
// the input register, and processing it loads the state and result.
// One held character is kept for two-character tokens; it is decided on the
// next beat or at end of line.
// Synchronous reset clears all tracking state; clear beats do the same.
// A stalled rsp holds the pipeline; req_tready drops only when both stages
// are full and rsp is not taken.
// ----------------------------------------------------------------------------
module c_brace_depth_lexer_top
   import cbd_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] ch
   input  logic                   req_tuser,   // [0] cmd
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [15:0] depth, [16] comment_open,
                                               // [17] string_open, [18] char_open
);

   // input stage
   logic            in_valid_ff, in_valid_in;
   logic            in_cmd_ff;
   logic [CH_W-1:0] in_ch_ff;
   logic            in_eol_ff;

   // tracking state
   cbd_flags_type         flags_ff, flags_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [CH_W-1:0]       held_ff, held_in;
   logic                  held_valid_ff, held_valid_in;

   // result stage
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_fire, proc_fire;

   assign proc_fire   = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || proc_fire;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !proc_fire);
   assign rsp_valid_in = proc_fire || (rsp_valid_ff && !rsp_tready);

   // first decision: held character with the new one as lookahead
   cbd_flags_type         d1_flags;
   logic [DEPTH_BITS-1:0] d1_depth;
   logic                  d1_consumed;

   cbd_decide #(.DEPTH_BITS(DEPTH_BITS)) u_held_decide (
      .flags_i    (flags_ff),
      .depth_i    (depth_ff),
      .c_i        (held_ff),
      .la_i       (in_ch_ff),
      .la_ok_i    (1'b1),
      .flags_o    (d1_flags),
      .depth_o    (d1_depth),
      .consumed_o (d1_consumed)
   );

   cbd_flags_type         s1_flags;
   logic [DEPTH_BITS-1:0] s1_depth;
   logic                  s1_consumed;

   assign s1_flags    = held_valid_ff ? d1_flags : flags_ff;
   assign s1_depth    = held_valid_ff ? d1_depth : depth_ff;
   assign s1_consumed = held_valid_ff && d1_consumed;

   // second decision: last character of a line, NUL lookahead
   cbd_flags_type         d2_flags;
   logic [DEPTH_BITS-1:0] d2_depth;
   logic                  d2_consumed;

   cbd_decide #(.DEPTH_BITS(DEPTH_BITS)) u_eol_decide (
      .flags_i    (s1_flags),
      .depth_i    (s1_depth),
      .c_i        (in_ch_ff),
      .la_i       ('0),
      .la_ok_i    (1'b0),
      .flags_o    (d2_flags),
      .depth_o    (d2_depth),
      .consumed_o (d2_consumed)
   );

   always_comb begin
      flags_in      = s1_flags;
      depth_in      = s1_depth;
      held_in       = '0;
      held_valid_in = 1'b0;
      if (in_cmd_ff == CMD_CLEAR) begin
         flags_in = '0;
         depth_in = '0;
      end else begin
         if (!s1_consumed && !s1_flags.skip) begin
            if (in_eol_ff) begin
               flags_in = d2_flags;
               depth_in = d2_depth;
            end else begin
               held_in       = in_ch_ff;
               held_valid_in = 1'b1;
            end
         end
         if (in_eol_ff) begin
            flags_in.skip = 1'b0;
            held_in       = '0;
            held_valid_in = 1'b0;
         end
      end
   end

   // depth sign-extended or clamped to the 16-bit result field
   logic [OUT_DEPTH_W-1:0] depth_out;

   generate
      if (DEPTH_BITS < OUT_DEPTH_W) begin : g_ext
         assign depth_out = {{(OUT_DEPTH_W-DEPTH_BITS){depth_in[DEPTH_BITS-1]}}, depth_in};
      end else if (DEPTH_BITS == OUT_DEPTH_W) begin : g_same
         assign depth_out = depth_in;
      end else begin : g_clamp
         localparam logic signed [DEPTH_BITS-1:0] OMAX = DEPTH_BITS'(32767);
         localparam logic signed [DEPTH_BITS-1:0] OMIN = -DEPTH_BITS'(32768);
         always_comb begin
            if ($signed(depth_in) > OMAX) begin
               depth_out = 16'h7FFF;
            end else if ($signed(depth_in) < OMIN) begin
               depth_out = 16'h8000;
            end else begin
               depth_out = depth_in[OUT_DEPTH_W-1:0];
            end
         end
      end
   endgenerate

   assign rsp_data_in = {5'b0, flags_in.chr, flags_in.str, flags_in.blk, depth_out};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flags_ff      <= '0;
         depth_ff      <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc_fire) begin
            flags_ff      <= flags_in;
            depth_ff      <= depth_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff <= req_tuser;
         in_ch_ff  <= req_tdata[CH_W-1:0];
         in_eol_ff <= req_tlast;
      end
      if (proc_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_cmd_ff == CMD_CLEAR |=> rsp_tdata == '0)
      else $error("clear beat did not give an all-zero result");

   a_lit_excl: assert property (@(posedge clock) disable iff (reset)
      !(flags_ff.str && flags_ff.chr))
      else $error("string and char literal open together");

   a_blk_excl: assert property (@(posedge clock) disable iff (reset)
      flags_ff.blk |-> !flags_ff.str && !flags_ff.chr)
      else $error("block comment open inside a literal");

   a_held_skip: assert property (@(posedge clock) disable iff (reset)
      !(held_valid_ff && flags_ff.skip))
      else $error("character held while skipping a line comment");

   a_eol_no_pair: assert property (@(posedge clock) disable iff (reset)
      !d2_consumed)
      else $error("end of line character paired with a NUL lookahead");

endmodule

// ===== tb/sv/tb_c_brace_depth_lexer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_brace_depth_lexer_top
// Self-checking bench for the brace depth lexer. A short table of directed
// beats covers comments, literals, escapes, end of line, clear and the
// zero byte. Random source text follows, with bursts of idle on both sides
// and one long output stall. Runs of opening and closing braces close the
// test with no idling. Each rsp beat is checked against a behavioral model
// of the lexer in the bench, or against a typed row's result in the table.
// ----------------------------------------------------------------------------
module tb_c_brace_depth_lexer_top
   import cbd_pkg::*;
();

   localparam int DEPTH_HI = (1 << (DEPTH_BITS_DEF - 1)) - 1;
   localparam int DEPTH_LO = -DEPTH_HI - 1;
   localparam int OUT_HI   = (1 << (OUT_DEPTH_W - 1)) - 1;
   localparam int OUT_LO   = -OUT_HI - 1;
   localparam int N_DIR    = 29;
   localparam int N_RAND   = 330;
   localparam int N_RUN    = 20;
   localparam int LONG_HOLD = 200;

   // packed so that it lines up with rsp_tdata[18:0]
   typedef struct packed {
      logic                          chr;
      logic                          str;
      logic                          blk;
      logic signed [OUT_DEPTH_W-1:0] depth;
   } scan_res_type;

   typedef struct packed {
      logic            cmd;
      logic [CH_W-1:0] ch;
      logic            eol;
      logic            typed;
      scan_res_type    want;
   } stim_row_type;

   localparam scan_res_type RES_ZERO = '0;

   localparam stim_row_type DIR_ROWS [0:N_DIR-1] = '{
      '{CMD_CLEAR, 8'hFF,        1'b1, 1'b1, RES_ZERO},
      '{CMD_CHAR,  CH_LBRACE,    1'b0, 1'b1, RES_ZERO},
      '{CMD_CHAR,  CH_LBRACE,    1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 16'sd2}},
      '{CMD_CHAR,  CH_SLASH,     1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_STAR,      1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_LBRACE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_STAR,      1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_SLASH,     1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_RBRACE,    1'b1, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_SLASH,     1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_SLASH,     1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_LBRACE,    1'b1, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_DQUOTE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_LBRACE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_DQUOTE,    1'b1, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_SQUOTE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_BACKSLASH, 1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_SQUOTE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_SQUOTE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_RBRACE,    1'b1, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_BACKSLASH, 1'b1, 1'b0, RES_ZERO},
      '{CMD_CHAR,  8'h00,        1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_RBRACE,    1'b1, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_LBRACE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CLEAR, CH_LBRACE,    1'b0, 1'b1, RES_ZERO},
      '{CMD_CHAR,  CH_DQUOTE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_BACKSLASH, 1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_DQUOTE,    1'b0, 1'b0, RES_ZERO},
      '{CMD_CHAR,  CH_DQUOTE,    1'b1, 1'b0, RES_ZERO}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [7:0] ch
   logic                   req_tuser;   // [0] cmd
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [15:0] depth, [16] comment_open,
                                        // [17] string_open, [18] char_open

   // lexer model state
   int              depth_cnt = 0;
   bit              blk_open  = 0;
   bit              str_open  = 0;
   bit              chr_open  = 0;
   logic [CH_W-1:0] held_ch   = '0;
   bit              held_vld  = 0;
   bit              line_skip = 0;

   scan_res_type scan_result_q[$];
   int           err_cnt  = 0;
   int           idle_pct = 0;
   bit           hold_req = 0;

   c_brace_depth_lexer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      err_cnt++;
   endtask

   // decide character c against lookahead la; 1 when la is eaten too
   function automatic bit resolve_char(input logic [CH_W-1:0] c, input logic [CH_W-1:0] la,
                                       input bit la_ok);
      bit plain;
      plain = !str_open && !chr_open;
      if (line_skip) return 1'b0;
      if (blk_open) begin
         if (c == CH_STAR && la_ok && la == CH_SLASH) begin
            blk_open = 1'b0;
            return 1'b1;
         end
         return 1'b0;
      end
      if (plain && c == CH_SLASH && la_ok && la == CH_STAR) begin
         blk_open = 1'b1;
         return 1'b1;
      end
      if (plain && c == CH_SLASH && la_ok && la == CH_SLASH) begin
         line_skip = 1'b1;
         return 1'b1;
      end
      if (c == CH_BACKSLASH && la_ok) return 1'b1;
      if (!chr_open && c == CH_DQUOTE) str_open = !str_open;
      else if (!str_open && c == CH_SQUOTE) chr_open = !chr_open;
      if (!str_open && !chr_open) begin
         if (c == CH_LBRACE) begin
            if (depth_cnt < DEPTH_HI) depth_cnt++;
         end else if (c == CH_RBRACE) begin
            if (depth_cnt > DEPTH_LO) depth_cnt--;
         end
      end
      return 1'b0;
   endfunction

   function automatic scan_res_type scan_char(input logic cmd, input logic [CH_W-1:0] ch,
                                              input logic eol);
      bit           eaten;
      int           d;
      scan_res_type r;
      if (cmd == CMD_CLEAR) begin
         depth_cnt = 0;
         blk_open  = 1'b0;
         str_open  = 1'b0;
         chr_open  = 1'b0;
         held_ch   = '0;
         held_vld  = 1'b0;
         line_skip = 1'b0;
      end else begin
         eaten = 1'b0;
         if (held_vld) begin
            eaten    = resolve_char(held_ch, ch, 1'b1);
            held_vld = 1'b0;
            held_ch  = '0;
         end
         if (!eaten && !line_skip) begin
            if (eol) begin
               void'(resolve_char(ch, '0, 1'b0));
            end else begin
               held_ch  = ch;
               held_vld = 1'b1;
            end
         end
         if (eol) begin
            line_skip = 1'b0;
            held_vld  = 1'b0;
            held_ch   = '0;
         end
      end
      d = depth_cnt;
      if (d > OUT_HI) d = OUT_HI;
      if (d < OUT_LO) d = OUT_LO;
      r.depth = d[OUT_DEPTH_W-1:0];
      r.blk   = blk_open;
      r.str   = str_open;
      r.chr   = chr_open;
      return r;
   endfunction

   // drive one req beat, wait for accept, record what it should produce
   task automatic send_char(input logic cmd, input logic [CH_W-1:0] ch, input logic eol,
                            input bit typed, input scan_res_type typed_res);
      int           n;
      scan_res_type r;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 12);
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= ch;
      req_tlast  <= eol;
      do @(posedge clock); while (!req_tready);
      r = scan_char(cmd, ch, eol);
      scan_result_q.push_back(typed ? typed_res : r);
   endtask

   function automatic logic [CH_W-1:0] pick_source_char();
      case ($urandom_range(0, 15))
         0, 1:    return CH_LBRACE;
         2, 3:    return CH_RBRACE;
         4, 5:    return CH_SLASH;
         6, 7:    return CH_STAR;
         8:       return CH_DQUOTE;
         9:       return CH_SQUOTE;
         10:      return CH_BACKSLASH;
         11:      return 8'h61;
         default: return CH_W'($urandom_range(1, 255));
      endcase
   endfunction

   // rsp side: random stalls, plus one long hold on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      scan_res_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (scan_result_q.size() == 0) begin
            flag_error($sformatf("rsp beat with nothing pending: %h", rsp_tdata));
         end else begin
            e = scan_result_q.pop_front();
            if (rsp_tdata[15:0] !== e.depth)
               flag_error($sformatf("depth %0d, want %0d",
                                    $signed(rsp_tdata[15:0]), e.depth));
            if (rsp_tdata[16] !== e.blk)
               flag_error($sformatf("comment_open %b, want %b", rsp_tdata[16], e.blk));
            if (rsp_tdata[17] !== e.str)
               flag_error($sformatf("string_open %b, want %b", rsp_tdata[17], e.str));
            if (rsp_tdata[18] !== e.chr)
               flag_error($sformatf("char_open %b, want %b", rsp_tdata[18], e.chr));
         end
      end
   end

   initial begin
      int              i;
      int              n;
      logic [CH_W-1:0] c;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_CHAR;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIR; i++)
         send_char(DIR_ROWS[i].cmd, DIR_ROWS[i].ch, DIR_ROWS[i].eol,
                   DIR_ROWS[i].typed, DIR_ROWS[i].want);

      for (i = 0; i < N_RAND; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 20;
               default: idle_pct = 50;
            endcase
         end
         if (i == 150) hold_req = 1'b1;
         if ($urandom_range(0, 63) == 0) begin
            send_char(CMD_CLEAR, CH_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, RES_ZERO);
         end else begin
            c = pick_source_char();
            send_char(CMD_CHAR, c, $urandom_range(0, 7) == 0, 1'b0, RES_ZERO);
         end
      end

      // brace runs, no idling from here on
      idle_pct = 0;
      send_char(CMD_CLEAR, 8'h00, 1'b0, 1'b1, RES_ZERO);
      repeat (N_RUN) send_char(CMD_CHAR, CH_LBRACE, 1'b1, 1'b0, RES_ZERO);
      send_char(CMD_CLEAR, 8'h00, 1'b1, 1'b1, RES_ZERO);
      repeat (N_RUN) send_char(CMD_CHAR, CH_RBRACE, 1'b1, 1'b0, RES_ZERO);
      req_tvalid <= 1'b0;

      n = 0;
      while (scan_result_q.size() != 0 && n < 5000) begin
         @(posedge clock);
         n++;
      end
      repeat (8) @(posedge clock);
      if (scan_result_q.size() != 0)
         flag_error($sformatf("%0d rsp beats never arrived", scan_result_q.size()));

      if (err_cnt == 0) begin
         $display("c_brace_depth_lexer_top: match");
      end else begin
         $display("c_brace_depth_lexer_top: mismatch");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout");
      $display("c_brace_depth_lexer_top: mismatch");
      $finish;
   end

endmodule

// ===== c_brace_depth_lexer_top.f =====
rtl/core/cbd_pkg.sv
rtl/core/cbd_decide.sv
rtl/core/c_brace_depth_lexer_top.sv
tb/sv/tb_c_brace_depth_lexer_top.sv
